FILE: sv/wedt_pkg.sv
// ---------------------------------------------------------------------------
// Wheel encoder delta tracker package
// Shared types, widths and command codes for the tracker and its helpers.
// ---------------------------------------------------------------------------
package wedt_pkg;

	localparam int NUM_WHEELS = 4;
	localparam int WHEEL_W    = 2;
	localparam int PULSE_W    = 16;
	localparam int FRAME_W    = 8;
	localparam int DELTA_W    = 24;
	localparam int MISSED_W   = 16;
	localparam int MASK_W     = 4;
	localparam int STEP_W     = PULSE_W + 2;

	// Unwrap thresholds: one third and two thirds of the pulse range
	localparam logic [PULSE_W-1:0] UP_LIMIT   = PULSE_W'(2 * 65535 / 3);
	localparam logic [PULSE_W-1:0] DOWN_LIMIT = PULSE_W'(65535 / 3);

	localparam logic signed [DELTA_W-1:0] DELTA_MAX = {1'b0, {(DELTA_W-1){1'b1}}};
	localparam logic signed [DELTA_W-1:0] DELTA_MIN = {1'b1, {(DELTA_W-1){1'b0}}};
	localparam logic [MISSED_W-1:0]       MISSED_MAX = {MISSED_W{1'b1}};

	// Command codes
	localparam logic CMD_READING = 1'b0;
	localparam logic CMD_REPORT  = 1'b1;

	typedef logic signed [DELTA_W-1:0] delta_t;
	typedef logic [MISSED_W-1:0]       missed_t;

	typedef struct packed {
		logic                 seen;
		logic [FRAME_W-1:0]   prev_frame;
		logic [PULSE_W-1:0]   prev_pulse;
		delta_t               delta;
		missed_t              missed;
	} wheel_state_t;

endpackage

FILE: sv/wedt_wheel_update.sv
// ---------------------------------------------------------------------------
// Wheel state update
// Folds one encoder reading into the state of its wheel: missed-frame gap,
// unwrapped pulse difference and saturating accumulation.
// ---------------------------------------------------------------------------
module wedt_wheel_update import wedt_pkg::*; (
	input  wheel_state_t       cur,
	input  logic [PULSE_W-1:0] pulses,
	input  logic [FRAME_W-1:0] frame_counter,
	output wheel_state_t       nxt
);

	logic signed [STEP_W-1:0]  diff;
	logic signed [STEP_W-1:0]  step;
	logic signed [DELTA_W:0]   dsum;
	logic [FRAME_W-1:0]        gap;
	logic [MISSED_W:0]         msum;
	delta_t                    delta_nxt;
	missed_t                   missed_nxt;

	// Unwrap the pulse difference across the 16-bit wrap
	assign diff = $signed({2'b00, pulses}) - $signed({2'b00, cur.prev_pulse});

	always_comb begin
		if (cur.prev_pulse > UP_LIMIT && pulses < DOWN_LIMIT) begin
			step = diff + $signed(STEP_W'(1 << PULSE_W));
		end else if (cur.prev_pulse < DOWN_LIMIT && pulses > UP_LIMIT) begin
			step = diff - $signed(STEP_W'(1 << PULSE_W));
		end else begin
			step = diff;
		end
	end

	// Accumulate the delta, clamp on overflow
	assign dsum = $signed({cur.delta[DELTA_W-1], cur.delta})
		+ $signed({{(DELTA_W+1-STEP_W){step[STEP_W-1]}}, step});

	always_comb begin
		if (dsum[DELTA_W] != dsum[DELTA_W-1]) begin
			delta_nxt = dsum[DELTA_W] ? DELTA_MIN : DELTA_MAX;
		end else begin
			delta_nxt = dsum[DELTA_W-1:0];
		end
	end

	// Count skipped frames; a repeated counter adds nothing
	assign gap  = frame_counter - cur.prev_frame - FRAME_W'(1);
	assign msum = {1'b0, cur.missed} + {{(MISSED_W+1-FRAME_W){1'b0}}, gap};

	always_comb begin
		if (frame_counter == cur.prev_frame) begin
			missed_nxt = cur.missed;
		end else if (msum[MISSED_W]) begin
			missed_nxt = MISSED_MAX;
		end else begin
			missed_nxt = msum[MISSED_W-1:0];
		end
	end

	// First reading only records the baseline
	always_comb begin
		nxt.seen       = 1'b1;
		nxt.prev_frame = frame_counter;
		nxt.prev_pulse = pulses;
		if (cur.seen) begin
			nxt.delta  = delta_nxt;
			nxt.missed = missed_nxt;
		end else begin
			nxt.delta  = cur.delta;
			nxt.missed = cur.missed;
		end
	end

endmodule

FILE: sv/wedt_report.sv
// ---------------------------------------------------------------------------
// Report formatter
// Applies the per-wheel invert mask to the accumulated deltas, clamping the
// negation of the most negative value.
// ---------------------------------------------------------------------------
module wedt_report import wedt_pkg::*; (
	input  delta_t              delta_in  [NUM_WHEELS],
	input  logic [MASK_W-1:0]   invert_mask,
	output delta_t              delta_out [NUM_WHEELS]
);

	// Negate where the mask bit is set
	for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_wheel
		always_comb begin
			if (!invert_mask[k]) begin
				delta_out[k] = delta_in[k];
			end else if (delta_in[k] == DELTA_MIN) begin
				delta_out[k] = DELTA_MAX;
			end else begin
				delta_out[k] = -delta_in[k];
			end
		end
	end

endmodule

FILE: sv/wheel_encoder_delta_tracker_unit.sv
// ---------------------------------------------------------------------------
// Wheel encoder delta tracker
// Per-wheel encoder tracking with missed-frame counting and report output.
// ---------------------------------------------------------------------------
// Accepts one request per cycle while no report is held in the input stage. A
// request is registered, then in the next cycle a reading updates its wheel's
// registers in a single read-modify-write; a report, once the output register
// is free, loads it and clears all accumulators, and its result then shows on
// out_valid. Readings keep flowing while a result waits; a report request holds
// in the input stage until the output register is free. invert_mask is written
// through the cfg channel, which is always ready.
module wheel_encoder_delta_tracker_unit import wedt_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [MASK_W-1:0]         cfg_data,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      cmd,
	input  logic [WHEEL_W-1:0]        wheel,
	input  logic [PULSE_W-1:0]        pulses,
	input  logic [FRAME_W-1:0]        frame_counter,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [DELTA_W-1:0] delta_front_left,
	output logic signed [DELTA_W-1:0] delta_front_right,
	output logic signed [DELTA_W-1:0] delta_rear_left,
	output logic signed [DELTA_W-1:0] delta_rear_right,
	output logic [MISSED_W-1:0]       missed_front_left,
	output logic [MISSED_W-1:0]       missed_front_right,
	output logic [MISSED_W-1:0]       missed_rear_left,
	output logic [MISSED_W-1:0]       missed_rear_right
);

	logic [MASK_W-1:0]  invert_mask_q;
	logic               valid_s1;
	logic               cmd_s1;
	logic [WHEEL_W-1:0] wheel_s1;
	logic [PULSE_W-1:0] pulses_s1;
	logic [FRAME_W-1:0] frame_s1;
	wheel_state_t       wheel_q [NUM_WHEELS];
	wheel_state_t       upd_nxt;
	delta_t             acc_delta [NUM_WHEELS];
	delta_t             rep_delta [NUM_WHEELS];
	delta_t             out_delta_q [NUM_WHEELS];
	missed_t            out_missed_q [NUM_WHEELS];
	logic               out_valid_q;
	logic               out_free;
	logic               s1_go;
	logic               in_fire;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || out_ready;
	assign s1_go     = valid_s1 && (cmd_s1 == CMD_READING || out_free);
	assign in_ready  = !valid_s1 || s1_go;
	assign in_fire   = in_valid && in_ready;

	// Hold the mask register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			invert_mask_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			invert_mask_q <= cfg_data;
		end
	end

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_s1    <= cmd;
			wheel_s1  <= wheel;
			pulses_s1 <= pulses;
			frame_s1  <= frame_counter;
		end
	end

	// Update the addressed wheel
	wedt_wheel_update u_update (
		.cur           (wheel_q[wheel_s1]),
		.pulses        (pulses_s1),
		.frame_counter (frame_s1),
		.nxt           (upd_nxt)
	);

	for (genvar k = 0; k < NUM_WHEELS; k++) begin : g_acc
		assign acc_delta[k] = wheel_q[k].delta;
	end

	wedt_report u_report (
		.delta_in    (acc_delta),
		.invert_mask (invert_mask_q),
		.delta_out   (rep_delta)
	);

	// Wheel registers: advance on a reading, clear accumulators on a report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_WHEELS; k++) begin
				wheel_q[k] <= '0;
			end
		end else if (s1_go) begin
			if (cmd_s1 == CMD_READING) begin
				wheel_q[wheel_s1] <= upd_nxt;
			end else begin
				for (int k = 0; k < NUM_WHEELS; k++) begin
					wheel_q[k].delta  <= '0;
					wheel_q[k].missed <= '0;
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && cmd_s1 == CMD_REPORT) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && cmd_s1 == CMD_REPORT) begin
			for (int k = 0; k < NUM_WHEELS; k++) begin
				out_delta_q[k]  <= rep_delta[k];
				out_missed_q[k] <= wheel_q[k].missed;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign delta_front_left   = out_delta_q[0];
	assign delta_front_right  = out_delta_q[1];
	assign delta_rear_left    = out_delta_q[2];
	assign delta_rear_right   = out_delta_q[3];
	assign missed_front_left  = out_missed_q[0];
	assign missed_front_right = out_missed_q[1];
	assign missed_rear_left   = out_missed_q[2];
	assign missed_rear_right  = out_missed_q[3];

endmodule

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// Wheel encoder delta tracker testbench
// Drives readings and reports through the request channel, with random
// idling on both sides and one long output stall. A predictor tracks each
// wheel's last count, frame and accumulators; every report result is
// compared field by field with the oldest pending prediction.
// ---------------------------------------------------------------------------
module testbench;
	import wedt_pkg::*;

	localparam int REPORTED_WHEELS = 4;
	localparam int SETTLE_CYCLES   = 4;
	localparam int LONG_HOLD       = 300;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int PHASES          = 9;
	localparam int HOLD_PHASE      = 2;
	localparam int SATURATE_PHASE  = 4;
	localparam int PHASE_ITEMS     = 50;
	localparam int HOLD_REPORTS    = 12;
	localparam int SATURATE_ROUNDS = 400;
	localparam int SAT_STEP        = 21845;
	localparam int LOWER_THIRD     = 65535 / 3;
	localparam int UPPER_THIRD     = 2 * 65535 / 3;
	localparam int DELTA_CEIL      = 8388607;
	localparam int DELTA_FLOOR     = -8388608;
	localparam int MISSED_CEIL     = 65535;

	typedef struct packed {
		logic [REPORTED_WHEELS-1:0][DELTA_W-1:0]  delta;
		logic [REPORTED_WHEELS-1:0][MISSED_W-1:0] missed;
	} tally_t;

	typedef struct packed {
		logic               cmd;
		logic [WHEEL_W-1:0] wheel;
		logic [PULSE_W-1:0] pulses;
		logic [FRAME_W-1:0] frame;
		bit                 typed;
		tally_t             want;
	} stim_row_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [MASK_W-1:0]         cfg_data;
	logic                      in_valid;
	logic                      in_ready;
	logic                      cmd;
	logic [WHEEL_W-1:0]        wheel;
	logic [PULSE_W-1:0]        pulses;
	logic [FRAME_W-1:0]        frame_counter;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [DELTA_W-1:0] delta_front_left;
	logic signed [DELTA_W-1:0] delta_front_right;
	logic signed [DELTA_W-1:0] delta_rear_left;
	logic signed [DELTA_W-1:0] delta_rear_right;
	logic [MISSED_W-1:0]       missed_front_left;
	logic [MISSED_W-1:0]       missed_front_right;
	logic [MISSED_W-1:0]       missed_rear_left;
	logic [MISSED_W-1:0]       missed_rear_right;

	// Predictor state: one slot per wheel plus the invert register
	bit                 seen_wheel [NUM_WHEELS];
	logic [FRAME_W-1:0] last_frame [NUM_WHEELS];
	logic [PULSE_W-1:0] last_count [NUM_WHEELS];
	int                 delta_sum  [NUM_WHEELS];
	int                 missed_sum [NUM_WHEELS];
	logic [MASK_W-1:0]  invert_bits;
	tally_t             pending_tallies [$];

	// Stimulus generator memory, kept apart from the predictor
	logic [PULSE_W-1:0] gen_count [REPORTED_WHEELS];
	logic [FRAME_W-1:0] gen_frame [REPORTED_WHEELS];

	int  mismatch_count;
	int  cycle_count;
	int  ready_hold;
	bit  hold_out_request;
	bit  no_idle;

	wheel_encoder_delta_tracker_unit u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_data           (cfg_data),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.cmd                (cmd),
		.wheel              (wheel),
		.pulses             (pulses),
		.frame_counter      (frame_counter),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.delta_front_left   (delta_front_left),
		.delta_front_right  (delta_front_right),
		.delta_rear_left    (delta_rear_left),
		.delta_rear_right   (delta_rear_right),
		.missed_front_left  (missed_front_left),
		.missed_front_right (missed_front_right),
		.missed_rear_left   (missed_rear_left),
		.missed_rear_right  (missed_rear_right)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				pending_tallies.size());
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what);
		$display("mismatch at cycle %0d: %s", cycle_count, what);
		mismatch_count++;
	endtask

	function automatic int clamp_delta(input int v);
		if (v > DELTA_CEIL)
			return DELTA_CEIL;
		if (v < DELTA_FLOOR)
			return DELTA_FLOOR;
		return v;
	endfunction

	// Signed pulse movement, unwrapped across the 16-bit rollover
	function automatic int pulse_step(input logic [PULSE_W-1:0] prev,
			input logic [PULSE_W-1:0] cur);
		int p;
		int c;
		p = prev;
		c = cur;
		if (p > UPPER_THIRD && c < LOWER_THIRD)
			return 65536 - p + c;
		if (p < LOWER_THIRD && c > UPPER_THIRD)
			return -(65536 - c + p);
		return c - p;
	endfunction

	// Advance the predictor by one accepted request
	task automatic track_request(input logic rq_cmd, input logic [WHEEL_W-1:0] rq_wheel,
			input logic [PULSE_W-1:0] rq_pulses, input logic [FRAME_W-1:0] rq_frame,
			output bit makes_report, output tally_t tally_out);
		int w;
		int k;
		int d;
		int m;
		int sum;
		logic [FRAME_W-1:0] gap;
		makes_report = 1'b0;
		tally_out = '0;
		w = rq_wheel;
		if (rq_cmd == CMD_READING) begin
			if (w < NUM_WHEELS) begin
				if (!seen_wheel[w]) begin
					// first reading of a wheel only stores it
					seen_wheel[w] = 1'b1;
					last_frame[w] = rq_frame;
					last_count[w] = rq_pulses;
				end else begin
					// a repeated counter adds no missed frames
					if (rq_frame != last_frame[w]) begin
						gap = rq_frame - last_frame[w] - 8'd1;
						sum = missed_sum[w] + int'(gap);
						missed_sum[w] = (sum > MISSED_CEIL) ? MISSED_CEIL : sum;
					end
					last_frame[w] = rq_frame;
					delta_sum[w] = clamp_delta(delta_sum[w] +
						pulse_step(last_count[w], rq_pulses));
					last_count[w] = rq_pulses;
				end
			end
		end else begin
			makes_report = 1'b1;
			for (k = 0; k < REPORTED_WHEELS; k++) begin
				d = 0;
				m = 0;
				if (k < NUM_WHEELS) begin
					d = delta_sum[k];
					m = missed_sum[k];
					if (invert_bits[k])
						d = clamp_delta(-d);
				end
				tally_out.delta[k]  = DELTA_W'(d);
				tally_out.missed[k] = MISSED_W'(m);
			end
			for (k = 0; k < NUM_WHEELS; k++) begin
				delta_sum[k]  = 0;
				missed_sum[k] = 0;
			end
		end
	endtask

	// Offer one request after a random gap, hold it until taken, then predict
	task automatic send_request(input logic rq_cmd, input logic [WHEEL_W-1:0] rq_wheel,
			input logic [PULSE_W-1:0] rq_pulses, input logic [FRAME_W-1:0] rq_frame,
			input bit typed, input tally_t typed_want);
		int gap;
		bit makes_report;
		tally_t predicted;
		gap = no_idle ? 0 : $urandom_range(12);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= rq_cmd;
		wheel         <= rq_wheel;
		pulses        <= rq_pulses;
		frame_counter <= rq_frame;
		do @(posedge clk); while (!in_ready);
		track_request(rq_cmd, rq_wheel, rq_pulses, rq_frame, makes_report, predicted);
		if (makes_report)
			pending_tallies.push_back(typed ? typed_want : predicted);
	endtask

	// Drop valid and wait for every pending report to come back
	task automatic drain_results;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_tallies.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_invert_mask(input logic [MASK_W-1:0] value);
		drain_results();
		// let trailing readings retire before touching the register
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		invert_bits = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_reading(input logic [WHEEL_W-1:0] w);
		send_request(CMD_READING, w, gen_count[w], gen_frame[w], 1'b0, '0);
	endtask

	function automatic stim_row_t make_row(input logic rq_cmd, input int w, input int p,
			input int f, input bit typed, input tally_t want);
		stim_row_t row;
		row.cmd    = rq_cmd;
		row.wheel  = WHEEL_W'(w);
		row.pulses = PULSE_W'(p);
		row.frame  = FRAME_W'(f);
		row.typed  = typed;
		row.want   = want;
		return row;
	endfunction

	function automatic tally_t make_tally(input int d0, input int d1, input int d2,
			input int d3, input int m0, input int m1, input int m2, input int m3);
		tally_t t;
		t.delta[0]  = DELTA_W'(d0);
		t.delta[1]  = DELTA_W'(d1);
		t.delta[2]  = DELTA_W'(d2);
		t.delta[3]  = DELTA_W'(d3);
		t.missed[0] = MISSED_W'(m0);
		t.missed[1] = MISSED_W'(m1);
		t.missed[2] = MISSED_W'(m2);
		t.missed[3] = MISSED_W'(m3);
		return t;
	endfunction

	// Output ready: long hold on request, else the per-result stall drawn below
	always @(negedge clk) begin
		if (hold_out_request) begin
			hold_out_request = 1'b0;
			ready_hold = LONG_HOLD;
		end
		if (ready_hold != 0) begin
			out_ready <= 1'b0;
			ready_hold--;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Compare each taken result with the oldest prediction
	always @(posedge clk) begin : result_check
		tally_t got;
		tally_t want;
		int k;
		if (arst_n && out_valid && out_ready) begin
			got.delta[0]  = delta_front_left;
			got.delta[1]  = delta_front_right;
			got.delta[2]  = delta_rear_left;
			got.delta[3]  = delta_rear_right;
			got.missed[0] = missed_front_left;
			got.missed[1] = missed_front_right;
			got.missed[2] = missed_rear_left;
			got.missed[3] = missed_rear_right;
			if (pending_tallies.size() == 0) begin
				flag_mismatch("report result with no request pending");
			end else begin
				want = pending_tallies.pop_front();
				for (k = 0; k < REPORTED_WHEELS; k++) begin
					if (got.delta[k] !== want.delta[k])
						flag_mismatch($sformatf("delta of wheel %0d: got %0d, want %0d", k,
							$signed(got.delta[k]), $signed(want.delta[k])));
					if (got.missed[k] !== want.missed[k])
						flag_mismatch($sformatf("missed of wheel %0d: got %0d, want %0d", k,
							got.missed[k], want.missed[k]));
				end
			end
			ready_hold = no_idle ? 0 : $urandom_range(12);
		end
	end

	initial begin : stimulus
		stim_row_t rows [$];
		stim_row_t row;
		int phase;
		int n;
		int i;
		int pstep;
		int unsigned dice;
		logic [WHEEL_W-1:0] w;
		logic [WHEEL_W-1:0] wa;
		logic [WHEEL_W-1:0] wb;
		logic [MASK_W-1:0] mask_value;

		arst_n           = 1'b0;
		cfg_valid        = 1'b0;
		cfg_data         = '0;
		in_valid         = 1'b0;
		cmd              = CMD_READING;
		wheel            = '0;
		pulses           = '0;
		frame_counter    = '0;
		out_ready        = 1'b0;
		invert_bits      = '0;
		mismatch_count   = 0;
		cycle_count      = 0;
		ready_hold       = 0;
		hold_out_request = 1'b0;
		no_idle          = 1'b0;
		for (i = 0; i < NUM_WHEELS; i++) begin
			seen_wheel[i] = 1'b0;
			last_frame[i] = '0;
			last_count[i] = '0;
			delta_sum[i]  = 0;
			missed_sum[i] = 0;
		end
		for (i = 0; i < REPORTED_WHEELS; i++) begin
			gen_count[i] = PULSE_W'($urandom);
			gen_frame[i] = FRAME_W'($urandom);
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed rows; typed results only where they are obvious
		rows.push_back(make_row(CMD_REPORT, 0, 0, 0, 1'b1, make_tally(0,0,0,0, 0,0,0,0)));
		rows.push_back(make_row(CMD_READING, 0, 100, 10, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 0, 200, 11, 1'b0, '0));
		// repeated counter on the front left wheel
		rows.push_back(make_row(CMD_READING, 0, 200, 11, 1'b0, '0));
		// upward wrap, counter rolls over
		rows.push_back(make_row(CMD_READING, 1, 65000, 255, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 1, 5, 2, 1'b0, '0));
		// downward wrap at the extremes with a repeated counter
		rows.push_back(make_row(CMD_READING, 2, 0, 0, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 2, 65535, 0, 1'b0, '0));
		// exactly on the upper threshold: no unwrap, widest frame gap
		rows.push_back(make_row(CMD_READING, 3, 0, 0, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 3, 43690, 255, 1'b0, '0));
		rows.push_back(make_row(CMD_REPORT, 0, 0, 0, 1'b1,
			make_tally(100, 541, -1, 43690, 0, 2, 0, 254)));
		// report fields at their extremes are ignored, accumulators already cleared
		rows.push_back(make_row(CMD_REPORT, 3, 65535, 255, 1'b1,
			make_tally(0,0,0,0, 0,0,0,0)));
		rows.push_back(make_row(CMD_READING, 3, 21845, 0, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 3, 65535, 1, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 3, 21844, 1, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 1, 0, 3, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 1, 43691, 3, 1'b0, '0));
		rows.push_back(make_row(CMD_READING, 0, 65535, 200, 1'b0, '0));
		rows.push_back(make_row(CMD_REPORT, 2, 12345, 77, 1'b0, '0));
		foreach (rows[i]) begin
			row = rows[i];
			send_request(row.cmd, row.wheel, row.pulses, row.frame, row.typed, row.want);
		end

		// Random phases, each under its own invert setting
		for (phase = 0; phase < PHASES; phase++) begin
			no_idle = (phase == 3 || phase == 7);
			if (phase == SATURATE_PHASE) begin
				// drive one wheel up and one down until both accumulators pin
				wa = WHEEL_W'($urandom_range(3));
				wb = wa + WHEEL_W'($urandom_range(3, 1));
				mask_value = MASK_W'($urandom_range(15));
				mask_value[wb] = 1'b1;
				write_invert_mask(mask_value);
				send_request(CMD_REPORT, '0, '0, '0, 1'b0, '0);
				for (i = 0; i < SATURATE_ROUNDS; i++) begin
					gen_count[wa] = gen_count[wa] + PULSE_W'(SAT_STEP);
					gen_frame[wa] = gen_frame[wa] - 8'd1;
					send_reading(wa);
					gen_count[wb] = gen_count[wb] - PULSE_W'(SAT_STEP);
					gen_frame[wb] = gen_frame[wb] - 8'd1;
					send_reading(wb);
				end
				send_request(CMD_REPORT, '0, '0, '0, 1'b0, '0);
			end else begin
				case (phase)
					0:       mask_value = 4'hF;
					1:       mask_value = 4'h0;
					default: mask_value = MASK_W'($urandom_range(15));
				endcase
				write_invert_mask(mask_value);
				if (phase == HOLD_PHASE) begin
					// stall the output while reports keep coming
					hold_out_request = 1'b1;
					for (i = 0; i < HOLD_REPORTS; i++)
						send_request(CMD_REPORT, WHEEL_W'($urandom), PULSE_W'($urandom),
							FRAME_W'($urandom), 1'b0, '0);
				end
				for (n = 0; n < PHASE_ITEMS; n++) begin
					if (n == PHASE_ITEMS / 2)
						drain_results();
					dice = $urandom_range(15);
					w = WHEEL_W'($urandom_range(3));
					if (dice < 2) begin
						send_request(CMD_REPORT, w, PULSE_W'($urandom), FRAME_W'($urandom),
							1'b0, '0);
					end else if (dice == 2) begin
						// noise: arbitrary count and counter
						gen_count[w] = PULSE_W'($urandom);
						gen_frame[w] = FRAME_W'($urandom);
						send_reading(w);
					end else begin
						// well-formed: mostly the next frame, else a random jump; modest or large movement
						if ($urandom_range(5) == 0)
							gen_frame[w] = gen_frame[w] + FRAME_W'($urandom_range(255));
						else
							gen_frame[w] = gen_frame[w] + 8'd1;
						if ($urandom_range(3) == 0)
							pstep = int'($urandom_range(65535)) - 32768;
						else
							pstep = int'($urandom_range(1000)) - 500;
						gen_count[w] = gen_count[w] + PULSE_W'(pstep);
						send_reading(w);
					end
				end
			end
		end

		drain_results();
		repeat (SETTLE_CYCLES * 2) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
